// ----- hw/rtl/u8cp_pkg.sv -----
// Shared types, constants and codes of the UTF-8 / codepage transcoder.
package u8cp_pkg;

    localparam int TABLE_DEPTH_DEF = 128;
    localparam int CP_W = 21;
    localparam int ENTRY_W = 16;

    localparam logic [1:0] REQ_DATA  = 2'd0;
    localparam logic [1:0] REQ_SRC_WR = 2'd1;
    localparam logic [1:0] REQ_TGT_WR = 2'd2;
    localparam logic [1:0] REQ_END   = 2'd3;

    localparam logic [2:0] ST_BYTE    = 3'd0;
    localparam logic [2:0] ST_ILLEGAL = 3'd1;
    localparam logic [2:0] ST_UNREP   = 3'd2;
    localparam logic [2:0] ST_TRUNC   = 3'd3;
    localparam logic [2:0] ST_END_OK  = 3'd4;

    localparam logic [1:0] CFG_SRC_ENC = 2'd0;
    localparam logic [1:0] CFG_TGT_ENC = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRC_READ,
        S_DECODE,
        S_SEARCH,
        S_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;      // latch accepted input item
        logic src_read;     // issue source table read
        logic decode;       // run decode step on captured item
        logic search_start; // reset search index
        logic search_step;  // advance search index
        logic emit_next;    // current output byte taken
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_search;  // decoded code point needs reverse search
        logic has_out;      // decode produced results
        logic search_hit;
        logic search_end;
        logic out_last;     // current output is the last one
    } stat_t;

endpackage

// ----- hw/rtl/u8cp_ctrl.sv -----
// Controller state machine of the transcoder.
module u8cp_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  logic [1:0]      req_type,
    output u8cp_pkg::cmd_t  cmd,
    input  u8cp_pkg::stat_t stat
);
    import u8cp_pkg::*;

    state_t state_reg, state_next;
    logic s_acc;
    logic m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    if (req_type == REQ_SRC_WR || req_type == REQ_TGT_WR)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SRC_READ;
                    end
                end
            end
            S_SRC_READ:
            begin
                state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (stat.need_search)
                begin
                    state_next = S_SEARCH;
                end
                else if (stat.has_out)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                if (stat.search_hit || stat.search_end)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (m_acc && stat.out_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.capture = s_acc;
            end
            S_SRC_READ:
            begin
                cmd.src_read = 1'b1;
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                cmd.search_start = 1'b1;
            end
            S_SEARCH:
            begin
                cmd.search_step = 1'b1;
            end
            S_EMIT:
            begin
                m_tvalid = 1'b1;
                cmd.emit_next = m_acc;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/u8cp_datapath.sv -----
// Datapath of the transcoder: tables, decode state, search and output bytes.
module u8cp_datapath
#(
    parameter int TABLE_DEPTH = u8cp_pkg::TABLE_DEPTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic            cfg_data,
    input  logic [1:0]      req_type,
    input  logic [7:0]      in_byte,
    input  logic [$clog2(TABLE_DEPTH)-1:0] table_index,
    input  logic [15:0]     table_value,
    input  logic            s_acc,
    input  u8cp_pkg::cmd_t  cmd,
    output u8cp_pkg::stat_t stat,
    output logic [7:0]      out_byte,
    output logic [2:0]      status
);
    import u8cp_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);

    logic [ENTRY_W-1:0] src_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] tgt_mem [TABLE_DEPTH];

    logic src_enc_reg, tgt_enc_reg;
    logic [CP_W-1:0] pend_reg;
    logic [1:0] expect_reg;
    logic [1:0] req_reg;
    logic [7:0] byte_reg;
    logic [ENTRY_W-1:0] src_q_reg;
    logic [ENTRY_W-1:0] tgt_q_reg;
    logic [IW-1:0] sidx_reg;
    logic [IW-1:0] qidx_reg;
    logic qval_reg;
    logic [CP_W-1:0] cp_reg;
    logic [7:0] ob_reg [4];
    logic [2:0] st_reg;
    logic [2:0] cnt_reg;
    logic [1:0] pos_reg;

    // Decode combinational results.
    logic [CP_W-1:0] cp_d;
    logic emit_cp;
    logic err_d;
    logic [2:0] err_st;
    logic [CP_W-1:0] pend_d;
    logic [1:0] expect_d;
    logic [CP_W-1:0] acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_enc_reg <= 1'b0;
            tgt_enc_reg <= 1'b0;
            pend_reg <= '0;
            expect_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_SRC_ENC)
            begin
                src_enc_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_TGT_ENC)
            begin
                tgt_enc_reg <= cfg_data;
            end
            if (cmd.decode)
            begin
                pend_reg <= pend_d;
                expect_reg <= expect_d;
            end
        end
    end

    // Table writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (s_acc && req_type == REQ_SRC_WR)
        begin
            src_mem[table_index] <= table_value;
        end
        if (s_acc && req_type == REQ_TGT_WR)
        begin
            tgt_mem[table_index] <= table_value;
        end
        if (cmd.src_read)
        begin
            src_q_reg <= src_mem[byte_reg[IW-1:0]];
        end
        tgt_q_reg <= tgt_mem[sidx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_type;
            byte_reg <= in_byte;
        end
    end

    always_comb
    begin
        cp_d = '0;
        emit_cp = 1'b0;
        err_d = 1'b0;
        err_st = ST_ILLEGAL;
        pend_d = pend_reg;
        expect_d = expect_reg;
        acc = {pend_reg[CP_W-7:0], byte_reg[5:0]};
        if (req_reg == REQ_END)
        begin
            err_d = 1'b1;
            err_st = (expect_reg != 2'd0) ? ST_TRUNC : ST_END_OK;
            pend_d = '0;
            expect_d = '0;
        end
        else if (src_enc_reg)
        begin
            pend_d = '0;
            expect_d = '0;
            if (!byte_reg[7])
            begin
                cp_d = CP_W'(byte_reg);
                emit_cp = 1'b1;
            end
            else if (src_q_reg == '0)
            begin
                err_d = 1'b1;
            end
            else
            begin
                cp_d = CP_W'(src_q_reg);
                emit_cp = 1'b1;
            end
        end
        else if (expect_reg != 2'd0)
        begin
            if (byte_reg[7:6] != 2'b10)
            begin
                err_d = 1'b1;
                pend_d = '0;
                expect_d = '0;
            end
            else if (expect_reg == 2'd1)
            begin
                cp_d = acc;
                emit_cp = 1'b1;
                pend_d = '0;
                expect_d = '0;
            end
            else
            begin
                pend_d = acc;
                expect_d = expect_reg - 2'd1;
            end
        end
        else if (!byte_reg[7])
        begin
            cp_d = CP_W'(byte_reg);
            emit_cp = 1'b1;
        end
        else if (byte_reg[7:5] == 3'b110)
        begin
            pend_d = CP_W'(byte_reg[4:0]);
            expect_d = 2'd1;
        end
        else if (byte_reg[7:4] == 4'b1110)
        begin
            pend_d = CP_W'(byte_reg[3:0]);
            expect_d = 2'd2;
        end
        else if (byte_reg[7:3] == 5'b11110)
        begin
            pend_d = CP_W'(byte_reg[2:0]);
            expect_d = 2'd3;
        end
        else
        begin
            err_d = 1'b1;
            pend_d = '0;
            expect_d = '0;
        end
    end

    logic need_search_d;
    assign need_search_d = emit_cp && tgt_enc_reg && (cp_d >= CP_W'(8'h80));

    // Output byte buffer, search index and compare pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            pos_reg <= '0;
            qval_reg <= 1'b0;
            sidx_reg <= '0;
            qidx_reg <= '0;
            cp_reg <= '0;
            st_reg <= ST_BYTE;
            ob_reg[0] <= 8'h00;
            ob_reg[1] <= 8'h00;
            ob_reg[2] <= 8'h00;
            ob_reg[3] <= 8'h00;
        end
        else
        begin
            if (cmd.search_start)
            begin
                sidx_reg <= '0;
                qval_reg <= 1'b0;
            end
            if (cmd.decode)
            begin
                cp_reg <= cp_d;
                pos_reg <= '0;
                st_reg <= ST_BYTE;
                ob_reg[1] <= 8'h00;
                ob_reg[2] <= 8'h00;
                ob_reg[3] <= 8'h00;
                if (err_d)
                begin
                    cnt_reg <= 3'd1;
                    st_reg <= err_st;
                    ob_reg[0] <= 8'h00;
                end
                else if (!emit_cp)
                begin
                    cnt_reg <= 3'd0;
                end
                else if (tgt_enc_reg || cp_d < CP_W'(12'h080))
                begin
                    cnt_reg <= 3'd1;
                    ob_reg[0] <= cp_d[7:0];
                end
                else if (cp_d < CP_W'(12'h800))
                begin
                    cnt_reg <= 3'd2;
                    ob_reg[0] <= 8'hC0 | 8'(cp_d[10:6]);
                    ob_reg[1] <= 8'h80 | 8'(cp_d[5:0]);
                end
                else if (cp_d < CP_W'(20'h10000))
                begin
                    cnt_reg <= 3'd3;
                    ob_reg[0] <= 8'hE0 | 8'(cp_d[15:12]);
                    ob_reg[1] <= 8'h80 | 8'(cp_d[11:6]);
                    ob_reg[2] <= 8'h80 | 8'(cp_d[5:0]);
                end
                else
                begin
                    cnt_reg <= 3'd4;
                    ob_reg[0] <= 8'hF0 | 8'(cp_d[20:18]);
                    ob_reg[1] <= 8'h80 | 8'(cp_d[17:12]);
                    ob_reg[2] <= 8'h80 | 8'(cp_d[11:6]);
                    ob_reg[3] <= 8'h80 | 8'(cp_d[5:0]);
                end
            end
            if (cmd.search_step)
            begin
                // tgt_q_reg holds the entry at qidx_reg when qval_reg is set.
                sidx_reg <= sidx_reg + IW'(1);
                qidx_reg <= sidx_reg;
                qval_reg <= 1'b1;
                if (stat.search_hit)
                begin
                    ob_reg[0] <= 8'h80 | 8'(qidx_reg);
                end
                else if (stat.search_end)
                begin
                    st_reg <= ST_UNREP;
                    ob_reg[0] <= 8'h00;
                end
            end
            if (cmd.emit_next)
            begin
                pos_reg <= pos_reg + 2'd1;
            end
        end
    end

    assign stat.need_search = need_search_d;
    assign stat.has_out = err_d || emit_cp;
    assign stat.search_hit = qval_reg && (CP_W'(tgt_q_reg) == cp_reg);
    assign stat.search_end = qval_reg && !stat.search_hit &&
                             (qidx_reg == IW'(TABLE_DEPTH - 1));
    assign stat.out_last = (3'(pos_reg) + 3'd1) >= cnt_reg;

    assign out_byte = ob_reg[pos_reg];
    assign status = st_reg;

endmodule

// ----- hw/rtl/utf8_codepage_transcoder.sv -----
// Top level of the byte-serial UTF-8 / single-byte codepage transcoder.
// One input transfer carries a data byte, a table write or an end-of-buffer marker. Table
// writes leave the controller idle. A data byte or end marker goes through accept, source table
// read and decode before its results, if any (one to four bytes or one status), go out one per
// transfer on the master side; when the target is a codepage and the code point is 0x80 or
// above, a reverse search walks the target table memory one entry per cycle before the result
// is sent.
// Both tables must be loaded before data flows; no clearing pass runs after reset.
// Configuration writes take effect at once and must be issued only while the block is idle.
module utf8_codepage_transcoder
#(
    parameter int TABLE_DEPTH = u8cp_pkg::TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // in_byte[7:0], table_index[14:8], table_value[30:15], zero pad [31]
    input  logic [31:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_byte[7:0]
    output logic [7:0]  m_tdata,
    // status[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);
    import u8cp_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);

    cmd_t  cmd;
    stat_t stat;
    logic  s_acc;

    assign s_acc = s_tvalid && s_tready;

    u8cp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .req_type (s_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

    u8cp_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (s_tuser),
        .in_byte     (s_tdata[7:0]),
        .table_index (s_tdata[8 +: IW]),
        .table_value (s_tdata[30:15]),
        .s_acc       (s_acc),
        .cmd         (cmd),
        .stat        (stat),
        .out_byte    (m_tdata),
        .status      (m_tuser)
    );

    assign m_tlast = stat.out_last;

    // The input side never accepts while a result is offered.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while output valid");

    // Status-only results are always single and carry a zero byte.
    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_BYTE) |-> (m_tlast && m_tdata == 8'h00))
        else $error("status result not single");

    // A stalled result holds its byte.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output changed while stalled");

endmodule

// ----- tb/sv/utf8_codepage_transcoder_tb.sv -----
// Self-checking testbench for the UTF-8 / single-byte codepage transcoder.
`timescale 1ns / 100ps

module utf8_codepage_transcoder_tb;
    import u8cp_pkg::*;

    // Register index beyond the two real registers; a write there must do nothing.
    localparam logic [1:0] CFG_SPARE = 2'd2;
    localparam int DEPTH = 128;
    // Cycles that an item causing no result may still be busy inside the block.
    localparam int SETTLE_CYCLES = 16;
    // Cycles waited at the end, after the last expected result, for stray results.
    localparam int TAIL_CYCLES = 160;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic        cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // Predictor state: a private copy of the registers, the tables and the
    // partial UTF-8 sequence being assembled.
    logic             src_is_codepage;
    logic             tgt_is_codepage;
    logic [20:0]      partial_point;
    logic [1:0]       tail_left;
    logic [15:0]      src_map [DEPTH];
    logic [15:0]      tgt_map [DEPTH];

    // Results predicted but not yet seen on the master side, oldest first.
    result_t expected_bytes [$];

    int  error_count;
    // When set, neither side inserts random idle cycles.
    bit  steady_flow;

    utf8_codepage_transcoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Generous upper bound on the run; reaching it means the block hung.
    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what);
        begin
            error_count++;
            $display("[%0t] MISMATCH: %s", $time, what);
        end
    endtask

    // Queue one expected result.
    task automatic push_byte(input logic [7:0] b, input logic [2:0] st, input logic lst);
        result_t r;
        begin
            r.out_byte = b;
            r.status   = st;
            r.last     = lst;
            expected_bytes.push_back(r);
        end
    endtask

    // Any status-only result also abandons a partial sequence.
    task automatic push_status(input logic [2:0] st);
        begin
            partial_point = '0;
            tail_left     = '0;
            push_byte(8'h00, st, 1'b1);
        end
    endtask

    // Encode one finished code point for the current target encoding.
    task automatic encode_point(input logic [20:0] cp);
        int hit;
        begin
            hit = -1;
            if (cp < 21'h80)
            begin
                push_byte(cp[7:0], ST_BYTE, 1'b1);
            end
            else if (tgt_is_codepage)
            begin
                // Reverse search: the lowest matching entry wins.
                for (int i = DEPTH - 1; i >= 0; i--)
                begin
                    if ({5'd0, tgt_map[i]} == cp)
                    begin
                        hit = i;
                    end
                end
                if (hit < 0)
                begin
                    push_status(ST_UNREP);
                end
                else
                begin
                    push_byte(8'h80 + 8'(hit), ST_BYTE, 1'b1);
                end
            end
            else if (cp < 21'h800)
            begin
                push_byte(8'hC0 | 8'(cp >> 6), ST_BYTE, 1'b0);
                push_byte(8'h80 | 8'(cp[5:0]), ST_BYTE, 1'b1);
            end
            else if (cp < 21'h10000)
            begin
                push_byte(8'hE0 | 8'(cp >> 12), ST_BYTE, 1'b0);
                push_byte(8'h80 | 8'(cp[11:6]), ST_BYTE, 1'b0);
                push_byte(8'h80 | 8'(cp[5:0]), ST_BYTE, 1'b1);
            end
            else
            begin
                push_byte(8'hF0 | 8'(cp >> 18), ST_BYTE, 1'b0);
                push_byte(8'h80 | 8'(cp[17:12]), ST_BYTE, 1'b0);
                push_byte(8'h80 | 8'(cp[11:6]), ST_BYTE, 1'b0);
                push_byte(8'h80 | 8'(cp[5:0]), ST_BYTE, 1'b1);
            end
        end
    endtask

    // Work out what one input item does to the state and which results it causes.
    task automatic predict_item(input logic [1:0] req, input logic [7:0] b,
                                input logic [6:0] idx, input logic [15:0] val);
        logic [20:0] cp;
        begin
            if (req == REQ_SRC_WR)
            begin
                src_map[idx] = val;
            end
            else if (req == REQ_TGT_WR)
            begin
                tgt_map[idx] = val;
            end
            else if (req == REQ_END)
            begin
                push_status((tail_left != 0) ? ST_TRUNC : ST_END_OK);
            end
            else if (src_is_codepage)
            begin
                // A pending UTF-8 sequence is dropped without a result.
                partial_point = '0;
                tail_left     = '0;
                cp = (b < 8'h80) ? {13'd0, b} : {5'd0, src_map[b[6:0]]};
                if (cp == 0 && b >= 8'h80)
                begin
                    push_status(ST_ILLEGAL);
                end
                else
                begin
                    encode_point(cp);
                end
            end
            else if (tail_left != 0)
            begin
                if (b[7:6] != 2'b10)
                begin
                    push_status(ST_ILLEGAL);
                end
                else
                begin
                    partial_point = {partial_point[14:0], b[5:0]};
                    tail_left     = tail_left - 2'd1;
                    if (tail_left == 0)
                    begin
                        cp = partial_point;
                        partial_point = '0;
                        encode_point(cp);
                    end
                end
            end
            else if (b < 8'h80)
            begin
                encode_point({13'd0, b});
            end
            else if (b[7:5] == 3'b110)
            begin
                partial_point = {16'd0, b[4:0]};
                tail_left     = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                partial_point = {17'd0, b[3:0]};
                tail_left     = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                partial_point = {18'd0, b[2:0]};
                tail_left     = 2'd3;
            end
            else
            begin
                push_status(ST_ILLEGAL);
            end
        end
    endtask

    // Send one item on the slave side. Valid stays high between back-to-back
    // transfers and is only lowered when an idle gap is inserted.
    task automatic send_item(input logic [1:0] req, input logic [7:0] b,
                             input logic [6:0] idx, input logic [15:0] val);
        begin
            if (!steady_flow && $urandom_range(99) < 20)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {1'b0, val, idx, b};
            s_tuser  <= req;
            predict_item(req, b, idx, val);
            do
            begin
                @(posedge clk);
            end
            while (!s_tready);
        end
    endtask

    task automatic send_data(input logic [7:0] b);
        begin
            send_item(REQ_DATA, b, 7'($urandom), 16'($urandom));
        end
    endtask

    task automatic send_end();
        begin
            send_item(REQ_END, 8'($urandom), 7'($urandom), 16'($urandom));
        end
    endtask

    // Drop valid and wait until every predicted result has been seen and the
    // block has had time to finish any item that causes no result.
    task automatic drain();
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (expected_bytes.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    // Register write; only called once the block has drained.
    task automatic write_reg(input logic [1:0] idx, input logic value);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(posedge clk);
            cfg_we    <= 1'b0;
            if (idx == CFG_SRC_ENC)
            begin
                src_is_codepage = value;
            end
            else if (idx == CFG_TGT_ENC)
            begin
                tgt_is_codepage = value;
            end
            @(posedge clk);
        end
    endtask

    task automatic write_reg_idle(input logic [1:0] idx, input logic value);
        begin
            drain();
            write_reg(idx, value);
        end
    endtask

    task automatic set_encodings(input logic src_cp, input logic tgt_cp);
        begin
            drain();
            write_reg(CFG_SRC_ENC, src_cp);
            write_reg(CFG_TGT_ENC, tgt_cp);
        end
    endtask

    // Send one code point as a well-formed UTF-8 sequence of the given length.
    task automatic send_utf8(input logic [20:0] cp, input int len);
        begin
            case (len)
                1: send_data({1'b0, cp[6:0]});
                2:
                begin
                    send_data({3'b110, cp[10:6]});
                    send_data({2'b10, cp[5:0]});
                end
                3:
                begin
                    send_data({4'b1110, cp[15:12]});
                    send_data({2'b10, cp[11:6]});
                    send_data({2'b10, cp[5:0]});
                end
                default:
                begin
                    send_data({5'b11110, cp[20:18]});
                    send_data({2'b10, cp[17:12]});
                    send_data({2'b10, cp[11:6]});
                    send_data({2'b10, cp[5:0]});
                end
            endcase
        end
    endtask

    // Fill both tables before any data flows. Most source entries also appear
    // in the target table so that reverse searches hit; a few source entries
    // are zero (undefined bytes) and a few point at code points found nowhere
    // in the target table.
    task automatic test_table_load();
        logic [15:0] v;
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                case (i)
                    0:  v = 16'hFFFF;
                    1:  v = 16'h0080;
                    2:  v = 16'h07FF;
                    3:  v = 16'h0800;
                    4:  v = 16'h0041;     // maps back into the ASCII range
                    5:  v = 16'h0000;     // undefined byte
                    6:  v = 16'h1234;     // absent from the target table
                    default: v = ($urandom_range(9) == 0) ? 16'h0000
                                 : 16'($urandom_range(16'h0080, 16'hFFFF));
                endcase
                send_item(REQ_SRC_WR, 8'($urandom), 7'(i), v);
            end
            for (int i = 0; i < DEPTH; i++)
            begin
                if (i == 6)
                begin
                    v = 16'h5555;
                end
                else if (i == 127)
                begin
                    v = 16'h0000;
                end
                else if ($urandom_range(3) == 0)
                begin
                    v = 16'($urandom);
                end
                else
                begin
                    v = src_map[i];
                end
                send_item(REQ_TGT_WR, 8'($urandom), 7'(i), v);
            end
        end
    endtask

    // UTF-8 in, UTF-8 out: size boundaries, bad leads, a broken sequence,
    // and both end-of-buffer outcomes.
    task automatic test_utf8_directed();
        begin
            set_encodings(1'b0, 1'b0);
            send_data(8'h00);
            send_data(8'h7F);
            send_utf8(21'h80, 2);
            send_utf8(21'h7FF, 2);
            send_utf8(21'h800, 3);
            send_utf8(21'hFFFF, 3);
            send_utf8(21'h10000, 4);
            send_utf8(21'h1FFFFF, 4);
            send_data(8'h80);
            send_data(8'hF8);
            send_data(8'hFF);
            send_data(8'hC2);
            send_data(8'h41);          // not a continuation byte: dropped
            send_data(8'hE2);
            send_end();                // sequence cut off
            send_end();                // nothing pending
        end
    endtask

    // Codepage paths, a mid-sequence switch of the source encoding, a register
    // write in the middle of a sequence, and a write to a spare index.
    task automatic test_codepage_directed();
        begin
            set_encodings(1'b1, 1'b1);
            send_data(8'h41);
            send_data(8'h80);          // entry 0xFFFF, found by search
            send_data(8'h84);          // maps into the ASCII range
            send_data(8'h85);          // undefined byte
            send_data(8'h86);          // unrepresentable in the target
            send_data(8'hFF);
            write_reg_idle(CFG_SPARE, 1'b1);
            set_encodings(1'b0, 1'b0);
            send_data(8'hE2);
            send_data(8'h82);
            drain();
            write_reg(CFG_SRC_ENC, 1'b1);
            send_data(8'h81);          // pending sequence dropped silently
            send_end();
            set_encodings(1'b0, 1'b0);
            send_data(8'hC2);
            drain();
            write_reg(CFG_TGT_ENC, 1'b1);
            send_data(8'h80);          // finishes U+0080 into the target table
            send_end();
        end
    endtask

    // Random traffic for one register setting. In UTF-8 input mode most items
    // are well-formed sequences, often of code points the target table holds.
    task automatic random_phase(input logic src_cp, input logic tgt_cp, input int items);
        int sent;
        int len;
        int pick;
        logic [20:0] cp;
        begin
            set_encodings(src_cp, tgt_cp);
            sent = 0;
            while (sent < items)
            begin
                pick = $urandom_range(99);
                if (pick < 4)
                begin
                    send_end();
                    sent++;
                end
                else if (pick < 6)
                begin
                    // Rewrite an entry with a defined value.
                    send_item(($urandom_range(1) != 0) ? REQ_SRC_WR : REQ_TGT_WR,
                              8'($urandom), 7'($urandom), 16'($urandom_range(1, 16'hFFFF)));
                    sent++;
                end
                else if (src_cp || pick < 16)
                begin
                    send_data(8'($urandom));
                    sent++;
                end
                else
                begin
                    len = $urandom_range(1, 4);
                    if (tgt_cp && $urandom_range(1) != 0)
                    begin
                        cp = {5'd0, tgt_map[$urandom_range(DEPTH - 1)]};
                        len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : 3;
                    end
                    else
                    begin
                        case (len)
                            1: cp = 21'($urandom_range(8'h7F));
                            2: cp = 21'($urandom_range(11'h7FF));
                            3: cp = 21'($urandom_range(16'hFFFF));
                            default: cp = 21'($urandom);
                        endcase
                    end
                    send_utf8(cp, len);
                    sent += len;
                end
            end
        end
    endtask

    task automatic test_random();
        begin
            random_phase(1'b0, 1'b0, 12);
            random_phase(1'b0, 1'b1, 12);
            // Hold the sender until everything predicted so far has come out.
            drain();
            random_phase(1'b1, 1'b0, 10);
            steady_flow = 1'b1;
            random_phase(1'b1, 1'b1, 10);
            steady_flow = 1'b0;
            random_phase(1'b0, 1'b1, 8);
        end
    endtask

    // Master side: random backpressure, and a check of every result transfer
    // against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= steady_flow || ($urandom_range(99) >= 20);
            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result byte %h status %0d",
                                              m_tdata, m_tuser));
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.out_byte)
                    begin
                        report_mismatch($sformatf("out_byte %h, expected %h",
                                                  m_tdata, want.out_byte));
                    end
                    if (m_tuser !== want.status)
                    begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_tuser, want.status));
                    end
                    if (m_tlast !== want.last)
                    begin
                        report_mismatch($sformatf("last %b, expected %b",
                                                  m_tlast, want.last));
                    end
                end
            end
        end
    end

    initial
    begin
        error_count     = 0;
        steady_flow     = 1'b0;
        src_is_codepage = 1'b0;
        tgt_is_codepage = 1'b0;
        partial_point   = '0;
        tail_left       = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            src_map[i] = '0;
            tgt_map[i] = '0;
        end
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_load();
        test_utf8_directed();
        test_codepage_directed();
        test_random();

        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
